[sv/cpf_pkg.sv]
// ============================================================================
// cpf_pkg
// Shared types, codes and the CRC-8 helper for the CRC-8 packet framer.
// ============================================================================
package cpf_pkg;

    // Input action codes.
    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_DATA  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN      = 2'd1;
    localparam logic [1:0] STATUS_OUT_OF_PLACE = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] REG_SYNC_FIRST  = 2'd1;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd2;

    // Register reset values.
    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd60;
    localparam logic [7:0] SYNC_FIRST_RESET  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'h55;

    // CRC-8 polynomial and top bit.
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // Configuration values seen by the front end.
    typedef struct packed {
        logic [7:0] max_payload;
        logic [7:0] sync_first;
        logic [7:0] sync_second;
    } cfg_t;

    // One command from the front end: one word, or three words in a row.
    typedef struct packed {
        logic       triple;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] status;
        logic       done;
    } cmd_t;

    // Feeds one byte into the CRC, MSB first.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'd0)
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[sv/cpf_in_if.sv]
// ============================================================================
// cpf_in_if
// Input channel: one framer item per word.
// ============================================================================
interface cpf_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] frame_length;
    logic [7:0] data_byte;

    modport source (output valid, output action, output frame_length,
                    output data_byte, input ready);
    modport sink   (input valid, input action, input frame_length,
                    input data_byte, output ready);
endinterface

[sv/cpf_out_if.sv]
// ============================================================================
// cpf_out_if
// Output channel: one frame byte or status per word.
// ============================================================================
interface cpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       frame_done;
    logic       run_last;

    modport source (output valid, output out_byte, output status,
                    output frame_done, output run_last, input ready);
    modport sink   (input valid, input out_byte, input status,
                    input frame_done, input run_last, output ready);
endinterface

[sv/cpf_regs.sv]
// ============================================================================
// cpf_regs
// APB-style register bank holding the payload limit and the sync bytes.
// ============================================================================
module cpf_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cpf_pkg::cfg_t      cfg
);

    logic [7:0] max_payload_reg;
    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic [1:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;

    // Register writes in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= cpf_pkg::MAX_PAYLOAD_RESET;
            sync_first_reg  <= cpf_pkg::SYNC_FIRST_RESET;
            sync_second_reg <= cpf_pkg::SYNC_SECOND_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                cpf_pkg::REG_MAX_PAYLOAD: max_payload_reg <= pwdata[7:0];
                cpf_pkg::REG_SYNC_FIRST:  sync_first_reg  <= pwdata[7:0];
                cpf_pkg::REG_SYNC_SECOND: sync_second_reg <= pwdata[7:0];
                default:                  ;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        unique case (reg_index)
            cpf_pkg::REG_MAX_PAYLOAD: prdata = {24'd0, max_payload_reg};
            cpf_pkg::REG_SYNC_FIRST:  prdata = {24'd0, sync_first_reg};
            cpf_pkg::REG_SYNC_SECOND: prdata = {24'd0, sync_second_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    assign cfg.max_payload = max_payload_reg;
    assign cfg.sync_first  = sync_first_reg;
    assign cfg.sync_second = sync_second_reg;

endmodule

[sv/cpf_front.sv]
// ============================================================================
// cpf_front
// Accepts items, keeps the frame state and CRC, and issues one command per item.
// ============================================================================
module cpf_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  cpf_pkg::cfg_t      cfg,
    cpf_in_if.sink             items,
    output logic               cmd_push,
    output cpf_pkg::cmd_t      cmd,
    input  logic               cmd_full
);

    logic [7:0] crc_acc_reg;
    logic [7:0] crc_acc_next;
    logic [7:0] seq_count_reg;
    logic [7:0] seq_count_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic       in_frame_reg;
    logic       in_frame_next;
    logic [7:0] crc_data;
    logic [7:0] crc_seq;
    logic [7:0] left_dec;

    assign items.ready = !cmd_full;
    assign cmd_push    = items.valid && !cmd_full;

    assign crc_data = cpf_pkg::crc8_feed(crc_acc_reg, items.data_byte);
    assign crc_seq  = cpf_pkg::crc8_feed(crc_data, seq_count_reg);
    assign left_dec = bytes_left_reg - 8'd1;

    // Classify the item and build its command.
    always_comb
    begin
        crc_acc_next    = crc_acc_reg;
        seq_count_next  = seq_count_reg;
        bytes_left_next = bytes_left_reg;
        in_frame_next   = in_frame_reg;
        cmd.triple      = 1'b0;
        cmd.byte0       = 8'd0;
        cmd.byte1       = 8'd0;
        cmd.byte2       = 8'd0;
        cmd.status      = cpf_pkg::STATUS_OK;
        cmd.done        = 1'b0;
        if (items.action == cpf_pkg::ACTION_START)
        begin
            priority if (in_frame_reg)
            begin
                cmd.status = cpf_pkg::STATUS_OUT_OF_PLACE;
            end
            else if (items.frame_length == 8'd0 || items.frame_length > cfg.max_payload)
            begin
                cmd.status = cpf_pkg::STATUS_BAD_LEN;
            end
            else
            begin
                cmd.triple      = 1'b1;
                cmd.byte0       = cfg.sync_first;
                cmd.byte1       = cfg.sync_second;
                cmd.byte2       = items.frame_length;
                crc_acc_next    = cpf_pkg::crc8_feed(8'd0, items.frame_length);
                bytes_left_next = items.frame_length;
                in_frame_next   = 1'b1;
            end
        end
        else
        begin
            priority if (!in_frame_reg)
            begin
                cmd.status = cpf_pkg::STATUS_OUT_OF_PLACE;
            end
            else if (left_dec != 8'd0)
            begin
                cmd.byte0       = items.data_byte;
                crc_acc_next    = crc_data;
                bytes_left_next = left_dec;
            end
            else
            begin
                // Last payload byte closes the frame with sequence and CRC.
                cmd.triple      = 1'b1;
                cmd.byte0       = items.data_byte;
                cmd.byte1       = seq_count_reg;
                cmd.byte2       = crc_seq;
                cmd.done        = 1'b1;
                crc_acc_next    = crc_seq;
                bytes_left_next = left_dec;
                seq_count_next  = seq_count_reg + 8'd1;
                in_frame_next   = 1'b0;
            end
        end
    end

    // Frame state, updated on each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_acc_reg    <= 8'd0;
            seq_count_reg  <= 8'd0;
            bytes_left_reg <= 8'd0;
            in_frame_reg   <= 1'b0;
        end
        else if (cmd_push)
        begin
            crc_acc_reg    <= crc_acc_next;
            seq_count_reg  <= seq_count_next;
            bytes_left_reg <= bytes_left_next;
            in_frame_reg   <= in_frame_next;
        end
    end

endmodule

[sv/cpf_cmd_fifo.sv]
// ============================================================================
// cpf_cmd_fifo
// Short command queue between the front end and the output sequencer.
// ============================================================================
module cpf_cmd_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cpf_pkg::cmd_t      push_cmd,
    output logic               full,
    input  logic               pop,
    output cpf_pkg::cmd_t      pop_cmd,
    output logic               empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cpf_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[sv/cpf_back.sv]
// ============================================================================
// cpf_back
// Output sequencer: plays each command out as one or three result words.
// ============================================================================
module cpf_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  cpf_pkg::cmd_t      cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    cpf_out_if.source          results
);

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    cpf_pkg::cmd_t cur_reg;
    logic          cur_valid_reg;
    logic [1:0]    phase_reg;
    logic [1:0]    phase_next;
    logic          last_word;
    logic          word_taken;

    assign word_taken = cur_valid_reg && results.ready;
    assign cmd_pop    = !cmd_empty && (!cur_valid_reg || (word_taken && last_word));

    // Word fields for the current phase.
    always_comb
    begin
        results.valid      = cur_valid_reg;
        results.status     = cur_reg.status;
        results.frame_done = 1'b0;
        unique case (phase_reg)
            PHASE_FIRST:
            begin
                results.out_byte = cur_reg.byte0;
                last_word        = !cur_reg.triple;
                phase_next       = PHASE_SECOND;
            end
            PHASE_SECOND:
            begin
                results.out_byte = cur_reg.byte1;
                last_word        = 1'b0;
                phase_next       = PHASE_THIRD;
            end
            PHASE_THIRD:
            begin
                results.out_byte   = cur_reg.byte2;
                results.frame_done = cur_reg.done;
                last_word          = 1'b1;
                phase_next         = PHASE_FIRST;
            end
            default:
            begin
                results.out_byte = 8'd0;
                last_word        = 1'b1;
                phase_next       = PHASE_FIRST;
            end
        endcase
        results.run_last = last_word;
    end

    // Command load and phase stepping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= PHASE_FIRST;
        end
        else if (!cur_valid_reg || (word_taken && last_word))
        begin
            cur_valid_reg <= !cmd_empty;
            phase_reg     <= PHASE_FIRST;
        end
        else if (word_taken)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
    end

endmodule

[sv/crc8_packet_framer_core.sv]
// ============================================================================
// crc8_packet_framer_core
// CRC-8 packet framer: sync bytes, length, payload, sequence and CRC-8.
// ============================================================================
//
//  Channel   Direction  Word
//  items     in         action, frame_length, data_byte
//  results   out        out_byte, status, frame_done, run_last
//  APB       in/out     max_payload, sync_first, sync_second at 0x0, 0x4, 0x8
//
// A data byte inside a frame gives one word.
// A good start item and the last payload byte give three words
// in the output sequencer; the command queue lets the next items enter meanwhile.
// Error items give one word each. Reset clears the frame state and the queue.
// The input stalls only when the command queue is full.
// ============================================================================
module crc8_packet_framer_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    cpf_in_if.sink      items,
    cpf_out_if.source   results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cpf_pkg::cfg_t cfg;
    cpf_pkg::cmd_t push_cmd;
    cpf_pkg::cmd_t pop_cmd;
    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_pop;
    logic          cmd_empty;

    // Configuration registers.
    cpf_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front end: classify items and track the frame.
    cpf_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .items    (items),
        .cmd_push (cmd_push),
        .cmd      (push_cmd),
        .cmd_full (cmd_full)
    );

    // Command queue.
    cpf_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .full     (cmd_full),
        .pop      (cmd_pop),
        .pop_cmd  (pop_cmd),
        .empty    (cmd_empty)
    );

    // Output sequencer.
    cpf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (pop_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .results   (results)
    );

    // An error word carries a zero byte and ends its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status != cpf_pkg::STATUS_OK)
            |-> (results.out_byte == 8'd0 && results.run_last && !results.frame_done))
        else $error("error word is not a lone zero byte");

    // The CRC word is always the last word of a good item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.frame_done)
            |-> (results.run_last && results.status == cpf_pkg::STATUS_OK))
        else $error("frame_done on a word that does not end a good item");

    // A pushed command never lands in a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command pushed into a full queue");

endmodule

[sim/frame_checker.sv]
// ============================================================================
// frame_checker
// Watches the item, result and APB ports of the CRC-8 packet framer, predicts
// every frame word from its own copy of the framer state and compares each
// returned word, field by field, with the oldest prediction.
// ============================================================================
module frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    cpf_in_if           items,
    cpf_out_if          results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int unsigned failures,
    output int unsigned pending
);

    // One word on the result channel.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       frame_done;
        logic       run_last;
    } frame_word_t;

    // Words predicted but not yet returned, oldest first.
    frame_word_t frame_words[$];

    // Mirrored configuration.
    logic [7:0] max_len;
    logic [7:0] sync_a;
    logic [7:0] sync_b;

    // Mirrored frame state.
    logic [7:0] frame_crc;
    logic [7:0] seq_num;
    logic [7:0] remaining;
    logic       frame_open;

    frame_word_t seen;
    frame_word_t want;

    // Bit-serial CRC-8 update, polynomial x^8 + x^2 + x + 1, MSB first.
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? cpf_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic frame_word_t make_word(input logic [7:0] b, input logic [1:0] st,
                                              input logic done, input logic last);
        frame_word_t w;
        w.out_byte   = b;
        w.status     = st;
        w.frame_done = done;
        w.run_last   = last;
        return w;
    endfunction

    // Works out the words that one accepted item causes and advances the state.
    task automatic predict_item(input logic act, input logic [7:0] len, input logic [7:0] dbyte);
        if (act == cpf_pkg::ACTION_START)
        begin
            if (frame_open)
            begin
                frame_words.push_back(make_word(8'h00, cpf_pkg::STATUS_OUT_OF_PLACE,
                                                1'b0, 1'b1));
            end
            else if (len == 8'd0 || len > max_len)
            begin
                frame_words.push_back(make_word(8'h00, cpf_pkg::STATUS_BAD_LEN,
                                                1'b0, 1'b1));
            end
            else
            begin
                frame_words.push_back(make_word(sync_a, cpf_pkg::STATUS_OK, 1'b0, 1'b0));
                frame_words.push_back(make_word(sync_b, cpf_pkg::STATUS_OK, 1'b0, 1'b0));
                frame_words.push_back(make_word(len, cpf_pkg::STATUS_OK, 1'b0, 1'b1));
                frame_crc  = crc_step(8'h00, len);
                remaining  = len;
                frame_open = 1'b1;
            end
        end
        else if (!frame_open)
        begin
            frame_words.push_back(make_word(8'h00, cpf_pkg::STATUS_OUT_OF_PLACE,
                                            1'b0, 1'b1));
        end
        else
        begin
            frame_crc = crc_step(frame_crc, dbyte);
            remaining = remaining - 8'd1;
            if (remaining != 8'd0)
            begin
                frame_words.push_back(make_word(dbyte, cpf_pkg::STATUS_OK, 1'b0, 1'b1));
            end
            else
            begin
                // Last payload byte closes the frame with sequence number and CRC.
                frame_words.push_back(make_word(dbyte, cpf_pkg::STATUS_OK, 1'b0, 1'b0));
                frame_words.push_back(make_word(seq_num, cpf_pkg::STATUS_OK, 1'b0, 1'b0));
                frame_crc = crc_step(frame_crc, seq_num);
                frame_words.push_back(make_word(frame_crc, cpf_pkg::STATUS_OK, 1'b1, 1'b1));
                seq_num    = seq_num + 8'd1;
                frame_open = 1'b0;
            end
        end
    endtask

    // Compare returned words first, then track configuration and new items.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_words.delete();
            max_len    = cpf_pkg::MAX_PAYLOAD_RESET;
            sync_a     = cpf_pkg::SYNC_FIRST_RESET;
            sync_b     = cpf_pkg::SYNC_SECOND_RESET;
            frame_crc  = 8'h00;
            seq_num    = 8'h00;
            remaining  = 8'h00;
            frame_open = 1'b0;
            failures   = 0;
            pending    = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                seen = make_word(results.out_byte, results.status, results.frame_done,
                                 results.run_last);
                if (frame_words.size() == 0)
                begin
                    $display("%0t: unexpected word byte=%02h status=%0d done=%0b last=%0b",
                             $time, seen.out_byte, seen.status, seen.frame_done,
                             seen.run_last);
                    failures++;
                end
                else
                begin
                    want = frame_words.pop_front();
                    if (seen.out_byte !== want.out_byte || seen.status !== want.status ||
                        seen.frame_done !== want.frame_done ||
                        seen.run_last !== want.run_last)
                    begin
                        $display({"%0t: word mismatch: expected byte=%02h status=%0d ",
                                  "done=%0b last=%0b, actual byte=%02h status=%0d ",
                                  "done=%0b last=%0b"},
                                 $time, want.out_byte, want.status, want.frame_done,
                                 want.run_last, seen.out_byte, seen.status,
                                 seen.frame_done, seen.run_last);
                        failures++;
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    cpf_pkg::REG_MAX_PAYLOAD: max_len = pwdata[7:0];
                    cpf_pkg::REG_SYNC_FIRST:  sync_a  = pwdata[7:0];
                    cpf_pkg::REG_SYNC_SECOND: sync_b  = pwdata[7:0];
                    default: ;
                endcase
            end

            if (items.valid && items.ready)
            begin
                predict_item(items.action, items.frame_length, items.data_byte);
            end

            pending = frame_words.size();
        end
    end

endmodule

[sim/tb.sv]
// ============================================================================
// tb
// Testbench for the CRC-8 packet framer. Drives items and register writes,
// idles and stalls both channels at random, and reports the checker's verdict.
// Phases cover error items, length limits, sync byte values, a run of
// back-to-back one-byte frames and a long output hold-off that backs up the input.
// ============================================================================
module tb;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int unsigned mismatch_count;
    int unsigned words_outstanding;

    // Idling controls for the sender and the receiver.
    bit          tx_steady;
    bit          rx_steady;
    bit          hold_request;
    logic [7:0]  len_cap;
    int unsigned items_pushed;

    cpf_in_if  in_ch();
    cpf_out_if out_ch();

    crc8_packet_framer_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (in_ch),
        .results (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    frame_checker frame_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (in_ch),
        .results  (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .failures (mismatch_count),
        .pending  (words_outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 24);
    endfunction

    // Offers one item and returns once it has been accepted.
    task automatic push_word(input logic act, input logic [7:0] len, input logic [7:0] dbyte);
        int unsigned gap;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.frame_length <= len;
        in_ch.data_byte    <= dbyte;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        items_pushed++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        psel        <= 1'b1;
        penable     <= 1'b0;
        pwrite      <= 1'b1;
        paddr       <= {idx, 2'b00};
        pwdata      <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == cpf_pkg::REG_MAX_PAYLOAD)
        begin
            len_cap = value;
        end
    endtask

    task automatic set_config(input logic [7:0] max_value, input logic [7:0] first,
                              input logic [7:0] second);
        write_reg(cpf_pkg::REG_MAX_PAYLOAD, max_value);
        write_reg(cpf_pkg::REG_SYNC_FIRST, first);
        write_reg(cpf_pkg::REG_SYNC_SECOND, second);
    endtask

    // Stops offering items and waits until every predicted word has come back.
    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (words_outstanding != 0 && waited < 50000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
    endtask

    // Start item whose length the block must reject.
    task automatic push_bad_start();
        logic [7:0] len;
        if (len_cap == 8'd255 || $urandom_range(0, 2) == 0)
        begin
            len = 8'd0;
        end
        else
        begin
            len = 8'($urandom_range(int'(len_cap) + 1, 255));
        end
        push_word(cpf_pkg::ACTION_START, len, 8'($urandom));
    endtask

    // A complete frame with random payload; now and then a stray start inside it.
    task automatic push_frame(input logic [7:0] len);
        push_word(cpf_pkg::ACTION_START, len, 8'($urandom));
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 4)
            begin
                push_word(cpf_pkg::ACTION_START, 8'($urandom), 8'($urandom));
            end
            push_word(cpf_pkg::ACTION_DATA, 8'($urandom), 8'($urandom));
        end
    endtask

    // Mostly well-formed frames, the rest error items between frames.
    task automatic random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned r;
        int unsigned top_len;
        int unsigned long_len;
        stop_at = items_pushed + count;
        while (items_pushed < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (len_cap == 8'd0 || r < 8)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    push_bad_start();
                end
                else
                begin
                    push_word(cpf_pkg::ACTION_DATA, 8'($urandom), 8'($urandom));
                end
            end
            else if (r < 14)
            begin
                push_bad_start();
            end
            else
            begin
                top_len  = (len_cap < 8'd8) ? int'(len_cap) : 8;
                long_len = (len_cap < 8'd32) ? int'(len_cap) : 32;
                if ($urandom_range(0, 99) < 92)
                begin
                    push_frame(8'($urandom_range(1, top_len)));
                end
                else
                begin
                    push_frame(8'($urandom_range(1, long_len)));
                end
            end
        end
    endtask

    // Result receiver: random stalls, steady stretches, and one long hold-off.
    initial
    begin
        int unsigned hold_cnt;
        int unsigned stall_cnt;
        int unsigned run_cnt;
        hold_cnt     = 0;
        stall_cnt    = 0;
        run_cnt      = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_cnt     = 300;
                hold_request = 1'b0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end
            else if (rx_steady)
            begin
                out_ch.ready <= 1'b1;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                out_ch.ready <= 1'b0;
            end
            else if (run_cnt > 0)
            begin
                run_cnt--;
                out_ch.ready <= 1'b1;
            end
            else
            begin
                run_cnt      = $urandom_range(0, 10);
                stall_cnt    = pick_gap(1'b0);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = 4'd0;
        pwdata             = 32'd0;
        in_ch.valid        = 1'b0;
        in_ch.action       = cpf_pkg::ACTION_START;
        in_ch.frame_length = 8'd0;
        in_ch.data_byte    = 8'd0;
        tx_steady          = 1'b0;
        rx_steady          = 1'b0;
        hold_request       = 1'b0;
        len_cap            = cpf_pkg::MAX_PAYLOAD_RESET;
        items_pushed       = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Error items and short frames under the reset configuration.
        push_word(cpf_pkg::ACTION_DATA, 8'hFF, 8'hFF);
        push_word(cpf_pkg::ACTION_START, 8'd0, 8'hFF);
        push_word(cpf_pkg::ACTION_START, cpf_pkg::MAX_PAYLOAD_RESET + 8'd1, 8'h00);
        push_word(cpf_pkg::ACTION_START, 8'd255, 8'hA5);
        push_word(cpf_pkg::ACTION_START, 8'd1, 8'h00);
        push_word(cpf_pkg::ACTION_DATA, 8'h00, 8'hFF);
        push_word(cpf_pkg::ACTION_START, 8'd3, 8'h3C);
        push_word(cpf_pkg::ACTION_START, 8'd2, 8'h00);
        push_word(cpf_pkg::ACTION_DATA, 8'hFF, 8'h00);
        push_word(cpf_pkg::ACTION_DATA, 8'h5A, 8'h80);
        push_word(cpf_pkg::ACTION_DATA, 8'h00, 8'h01);
        push_word(cpf_pkg::ACTION_DATA, 8'h00, 8'h7F);
        push_word(cpf_pkg::ACTION_START, 8'd2, 8'hFF);
        push_word(cpf_pkg::ACTION_DATA, 8'h00, 8'hAA);
        push_word(cpf_pkg::ACTION_DATA, 8'h00, 8'h55);
        drain_results();

        // Zero length limit: every start is rejected.
        set_config(8'd0, 8'h0F, 8'hF0);
        push_word(cpf_pkg::ACTION_START, 8'd1, 8'h00);
        push_word(cpf_pkg::ACTION_START, 8'd255, 8'hFF);
        push_word(cpf_pkg::ACTION_DATA, 8'h80, 8'h12);
        random_traffic(12);
        drain_results();

        // One-byte frames back to back on both sides.
        set_config(8'd1, 8'h00, 8'hFF);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (int i = 0; i < 20; i++)
        begin
            push_frame(8'd1);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain_results();

        // A long frame while the receiver holds off, so the input backs up.
        set_config(8'd255, 8'hFF, 8'h00);
        @(posedge clk);
        hold_request = 1'b1;
        tx_steady    = 1'b1;
        push_word(cpf_pkg::ACTION_START, 8'd30, 8'h00);
        for (int i = 0; i < 30; i++)
        begin
            push_word(cpf_pkg::ACTION_DATA, 8'($urandom), 8'($urandom));
        end
        tx_steady = 1'b0;
        drain_results();

        // Random traffic under several settings, with and without idling.
        random_traffic(40);
        drain_results();
        set_config(8'($urandom_range(2, 20)), 8'($urandom), 8'($urandom));
        random_traffic(40);
        drain_results();
        set_config(cpf_pkg::MAX_PAYLOAD_RESET, cpf_pkg::SYNC_FIRST_RESET,
                   cpf_pkg::SYNC_SECOND_RESET);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        random_traffic(40);
        drain_results();
        set_config(8'd1, 8'($urandom), 8'($urandom));
        tx_steady = 1'b0;
        random_traffic(30);
        rx_steady = 1'b0;
        drain_results();
        set_config(8'($urandom_range(3, 12)), 8'($urandom), 8'($urandom));
        random_traffic(30);
        drain_results();

        if (words_outstanding != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, words_outstanding);
        end
        if (mismatch_count == 0 && words_outstanding == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
